@@ src/ssos_pkg.sv @@
`timescale 1ns / 1ps
package ssos_pkg;

	localparam int BYTE_W        = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int SEP_REG_BYTES = 8;   // bytes held in the separator register
	localparam int COUNT_W       = 16;

	typedef logic [BYTE_W-1:0] byte_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_LIMIT  = 2'd3;

	localparam logic [3:0]            SEP_LEN_RST   = 4'd1;
	localparam logic [CFG_DATA_W-1:0] SEP_BYTES_RST = 64'd32;   // single space

endpackage

@@ src/stream_split_on_separator.sv @@
`timescale 1ns / 1ps
// Splits a byte stream at a configurable separator of 1 to SEP_MAX_BYTES
// bytes (leftmost, non-overlapping matches) and sends the pieces out one
// byte per transaction, each piece closed by a marker transaction; empty
// pieces are dropped, and in limit mode the string after split_limit
// separators leaves as one final piece that is closed even when empty.
// Every input transaction is evaluated in the cycle it is accepted and its
// results appear on the master side from the next cycle on, one per cycle
// while m_tready is high; throughput is then one input transaction per
// cycle as long as each one causes at most one result. After a transaction
// that causes several results the next one is taken only as the last of
// them leaves, because the single output port drains the result holder one
// result per cycle. The largest burst, at end of string, is SEP_MAX_BYTES + 1
// results; a partial match that falls apart without ending the string
// gives at most SEP_MAX_BYTES. There is no clearing pass after reset. The
// match window is a row of SEP_MAX_BYTES cells that shift in every accepted
// byte, each comparing its byte against all separator bytes so that the
// longest window suffix that is a separator prefix is found combinationally.
module stream_split_on_separator #(
	parameter int SEP_MAX_BYTES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssos_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [7:0] data_byte
	input  logic                               s_tuser,   // [0] has_byte
	input  logic                               s_tlast,   // end_of_string
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata,   // [7:0] out_byte
	output logic [1:0]                         m_tuser,   // [0] out_has_byte, [1] piece_end
	output logic                               m_tlast    // run_last
);
	import ssos_pkg::*;

	localparam int N  = SEP_MAX_BYTES;
	localparam int LW = $clog2(N + 1);   // window fill, separator length
	localparam int CW = $clog2(N + 3);   // results per transaction
	localparam int IW = (N > 1) ? $clog2(N) : 1;

	// configuration registers
	logic [3:0]            sep_len_q;
	logic [CFG_DATA_W-1:0] sep_bytes_q;
	logic                  limit_en_q;
	logic [COUNT_W-1:0]    split_limit_q;

	// string state
	logic [LW-1:0]         fill_q;
	logic [COUNT_W-1:0]    seen_q;
	logic                  tail_q;
	logic                  open_q;

	byte_t                 sep [N];
	byte_t                 cw [N+1];     // cw[0] is the incoming byte
	logic [N-1:0]          eqv [N];
	logic [N-1:0]          match;        // match[k-1]: last k bytes are a separator prefix

	logic [LW-1:0]         len;
	logic [LW-1:0]         f_app;
	logic [LW-1:0]         kbest;
	logic [LW-1:0]         npop;
	logic                  acc, has, eos, active;
	logic                  tail_now, matched, open_mid, tail_after;
	logic                  mark_a, mark_b;
	logic [COUNT_W-1:0]    seen_inc;
	logic [CW-1:0]         total;
	byte_t                 pop_bytes [N];
	logic                  can_load;
	logic                  out_has, out_end;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_len_q     <= SEP_LEN_RST;
			sep_bytes_q   <= SEP_BYTES_RST;
			limit_en_q    <= 1'b0;
			split_limit_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SEP_LEN:      sep_len_q     <= cfg_data[3:0];
				CFG_SEP_BYTES:    sep_bytes_q   <= cfg_data;
				CFG_LIMIT_ENABLE: limit_en_q    <= cfg_data[0];
				CFG_SPLIT_LIMIT:  split_limit_q <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// separator bytes beyond the register read as zero
	for (genvar g = 0; g < N; g++) begin : g_sep
		if (g < SEP_REG_BYTES) begin : g_reg
			assign sep[g] = sep_bytes_q[BYTE_W*g +: BYTE_W];
		end else begin : g_zero
			assign sep[g] = '0;
		end
	end

	// effective separator length: 0 acts as 1, clipped at the window size
	always_comb begin
		if (sep_len_q == '0) begin
			len = LW'(1);
		end else if (int'(sep_len_q) > N) begin
			len = LW'(N);
		end else begin
			len = LW'(sep_len_q);
		end
	end

	assign acc    = s_tvalid && s_tready;
	assign has    = s_tuser;
	assign eos    = s_tlast;
	assign active = has || eos;

	// window cells, newest byte in cell 0
	assign cw[0] = s_tdata;
	for (genvar g = 0; g < N; g++) begin : g_cell
		ssos_cell #(
			.SEP_MAX_BYTES(N)
		) u_cell (
			.clk   (clk),
			.shift (acc && has),
			.d     (cw[g]),
			.sep   (sep),
			.q     (cw[g+1]),
			.eq    (eqv[g])
		);
	end

	// suffix of length k: cell i input must equal separator byte k-1-i
	always_comb begin
		logic m;
		for (int k = 1; k <= N; k++) begin
			m = 1'b1;
			for (int i = 0; i < k; i++) begin
				m = m & eqv[i][k-1-i];
			end
			match[k-1] = m;
		end
	end

	// window fill once the incoming byte is appended
	assign f_app = fill_q + LW'(has);

	// longest suffix still a separator prefix; the rest falls out as bytes
	always_comb begin
		kbest = '0;
		for (int k = 1; k <= N; k++) begin
			if (match[k-1] && (LW'(k) <= f_app) && (LW'(k) <= len)) begin
				kbest = LW'(k);
			end
		end
	end

	assign tail_now = tail_q || (limit_en_q && (seen_q >= split_limit_q));
	assign matched  = !tail_now && has && (kbest == len);
	assign seen_inc = (seen_q == '1) ? seen_q : seen_q + COUNT_W'(1);

	always_comb begin
		if (!active) begin
			npop = '0;
		end else if (tail_now) begin
			npop = f_app;               // tail: everything held plus the new byte
		end else if (matched) begin
			npop = f_app - len;         // bytes ahead of the separator
		end else if (eos) begin
			npop = f_app;               // flush at end of string
		end else begin
			npop = f_app - kbest;
		end
	end

	assign open_mid   = open_q || (npop != '0);
	assign tail_after = tail_now ||
		(matched && limit_en_q && (seen_inc >= split_limit_q));
	assign mark_a     = matched && open_mid;
	assign mark_b     = eos && (tail_after || (!matched && open_mid));
	assign total      = CW'(npop) + CW'(mark_a) + CW'(mark_b);

	// popped bytes leave oldest first; the oldest held byte sits in cw[fill_q]
	always_comb begin
		int idx;
		for (int j = 0; j < N; j++) begin
			idx = int'(fill_q) - j;
			if (idx >= 0) begin
				pop_bytes[j] = cw[idx[IW-1:0]];
			end else begin
				pop_bytes[j] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			seen_q <= '0;
			tail_q <= 1'b0;
			open_q <= 1'b0;
		end else if (acc && active) begin
			if (eos) begin
				fill_q <= '0;
				seen_q <= '0;
				tail_q <= 1'b0;
				open_q <= 1'b0;
			end else if (tail_now) begin
				fill_q <= '0;
				tail_q <= 1'b1;
				open_q <= open_mid;
			end else if (matched) begin
				fill_q <= '0;
				seen_q <= seen_inc;
				tail_q <= tail_after;
				open_q <= 1'b0;
			end else begin
				fill_q <= kbest;
				open_q <= open_mid;
			end
		end
	end

	ssos_burst #(
		.SEP_MAX_BYTES(N)
	) u_burst (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (acc && (total != '0)),
		.load_bytes    (pop_bytes),
		.load_nbytes   (npop),
		.load_total    (total),
		.can_load      (can_load),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_byte      (m_tdata),
		.out_has_byte  (out_has),
		.out_piece_end (out_end),
		.out_last      (m_tlast)
	);

	assign m_tuser  = {out_end, out_has};
	assign s_tready = can_load;

	// tail mode never holds bytes back
	a_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q |-> (fill_q == '0))
		else $error("window holds bytes in tail mode");

	// end of string clears all string state
	a_eos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tlast) |=> ((fill_q == '0) && (seen_q == '0) && !tail_q && !open_q))
		else $error("string state not cleared after end of string");

	// an empty result holder never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no result pending");

	// a partial match is always shorter than the window
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && has && !eos) |=> (int'(fill_q) < N))
		else $error("window fill reached the window size");

endmodule

@@ src/ssos_cell.sv @@
`timescale 1ns / 1ps
// One window cell: holds one string byte, passes it to the next cell on a
// shift, and compares its incoming byte with every separator byte.
module ssos_cell #(
	parameter int SEP_MAX_BYTES = 8
) (
	input  logic                     clk,
	input  logic                     shift,
	input  ssos_pkg::byte_t          d,
	input  ssos_pkg::byte_t          sep [SEP_MAX_BYTES],
	output ssos_pkg::byte_t          q,
	output logic [SEP_MAX_BYTES-1:0] eq
);
	import ssos_pkg::*;

	always_ff @(posedge clk) begin
		if (shift) begin
			q <= d;
		end
	end

	always_comb begin
		for (int p = 0; p < SEP_MAX_BYTES; p++) begin
			eq[p] = (d == sep[p]);
		end
	end

endmodule

@@ src/ssos_burst.sv @@
`timescale 1ns / 1ps
// Result holder: takes the full result list of one transaction and hands it
// out one result per cycle while out_ready is high, piece bytes first, then the markers.
module ssos_burst #(
	parameter int SEP_MAX_BYTES = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  ssos_pkg::byte_t                        load_bytes [SEP_MAX_BYTES],
	input  logic [$clog2(SEP_MAX_BYTES+1)-1:0]     load_nbytes,
	input  logic [$clog2(SEP_MAX_BYTES+3)-1:0]     load_total,
	output logic                                   can_load,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output ssos_pkg::byte_t                        out_byte,
	output logic                                   out_has_byte,
	output logic                                   out_piece_end,
	output logic                                   out_last
);
	import ssos_pkg::*;

	localparam int LW = $clog2(SEP_MAX_BYTES + 1);
	localparam int CW = $clog2(SEP_MAX_BYTES + 3);
	localparam int IW = (SEP_MAX_BYTES > 1) ? $clog2(SEP_MAX_BYTES) : 1;

	byte_t          bytes_q [SEP_MAX_BYTES];
	logic [LW-1:0]  nbytes_q;
	logic [CW-1:0]  total_q;
	logic [CW-1:0]  idx_q;

	assign out_valid     = (total_q != '0);
	assign out_last      = (idx_q == total_q - CW'(1));
	assign out_has_byte  = (idx_q < CW'(nbytes_q));
	assign out_piece_end = !out_has_byte;
	assign out_byte      = out_has_byte ? bytes_q[idx_q[IW-1:0]] : '0;
	assign can_load      = !out_valid || (out_last && out_ready);

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= load_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbytes_q <= '0;
			total_q  <= '0;
			idx_q    <= '0;
		end else if (load) begin
			nbytes_q <= load_nbytes;
			total_q  <= load_total;
			idx_q    <= '0;
		end else if (out_valid && out_ready) begin
			if (out_last) begin
				total_q <= '0;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

endmodule
